// ----- rtl/modbus_tcp_response_checker_unit_assert.svh -----
// Assertion macros shared by the response checker RTL.
`ifndef MODBUS_TCP_RESPONSE_CHECKER_UNIT_ASSERT_SVH
`define MODBUS_TCP_RESPONSE_CHECKER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MTRC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("response checker: implication check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define MTRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("response checker: next-cycle check failed");

`endif

// ----- rtl/mtrc_pkg.sv -----
// Shared widths, protocol constants and verdict codes of the response checker.
`default_nettype none

package mtrc_pkg;

    localparam int TidWidth    = 16;
    localparam int FcWidth     = 8;
    localparam int ByteWidth   = 8;
    localparam int WordWidth   = 16;
    localparam int StatusWidth = 2;

    localparam logic [7:0]  ExcFlag    = 8'h80;
    localparam logic [7:0]  BusyCode   = 8'h06;
    localparam logic [15:0] ProtoZero  = 16'h0000;
    localparam logic [7:0]  FcCoils    = 8'h01;
    localparam logic [7:0]  FcRegs     = 8'h03;
    localparam logic [15:0] HeaderLast = 16'd6;

    typedef enum logic [StatusWidth-1:0] {
        VERDICT_OK        = 2'd0,
        VERDICT_INVALID   = 2'd1,
        VERDICT_EXCEPTION = 2'd2,
        VERDICT_BUSY      = 2'd3
    } verdict_t;

endpackage

`default_nettype wire

// ----- rtl/mtrc_if.sv -----
// Valid/ready stream interfaces for the byte input and the result output.
`default_nettype none

interface mtrc_in_if;
    logic                            valid;
    logic                            ready;
    logic                            cmd;
    logic [mtrc_pkg::TidWidth-1:0]   expected_tid;
    logic [mtrc_pkg::FcWidth-1:0]    expected_fc;
    logic [mtrc_pkg::ByteWidth-1:0]  data_byte;

    modport source (output valid, cmd, expected_tid, expected_fc, data_byte, input ready);
    modport sink   (input valid, cmd, expected_tid, expected_fc, data_byte, output ready);
endinterface

interface mtrc_out_if;
    logic                              valid;
    logic                              ready;
    logic                              is_status;
    logic [mtrc_pkg::WordWidth-1:0]    payload_value;
    logic [mtrc_pkg::StatusWidth-1:0]  status;
    logic [mtrc_pkg::ByteWidth-1:0]    exception_code;
    logic                              last;

    modport source (output valid, is_status, payload_value, status, exception_code, last,
                    input ready);
    modport sink   (input valid, is_status, payload_value, status, exception_code, last,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/modbus_tcp_response_checker_unit.sv -----
// Top level of the Modbus TCP response checker: MBAP parse, PDU checks, result queue.
`default_nettype none
`include "modbus_tcp_response_checker_unit_assert.svh"

// Usage
// The bytes channel carries one request per cycle: cmd = 0 arms a new
// transaction with the expected transaction id and function code, cmd = 1
// delivers one response byte in wire order. A byte seen while not armed is
// dropped, and an arm in the middle of a frame abandons it silently.
// The results channel carries payload items (coil bytes for code 1, register
// words for code 3) and one status item with last set that closes each frame.
// Each accepted request is parsed in the cycle it is accepted, and its results
// are written to a three-entry result queue, whose head entry (entry 0)
// drives the results channel straight from its registers.
// Throughput is one request per cycle. The queue takes new requests while it
// holds at most one result; a request that closes a register or coil frame
// can add two results, which can still cause back-pressure even when the
// receiver takes one result per cycle. When the receiver stalls, results wait
// in the queue and the bytes channel drops ready once two are waiting.
// Reset empties the queue and returns the parser to the unarmed state.
module modbus_tcp_response_checker_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    mtrc_in_if.sink    bytes,
    mtrc_out_if.source results
);

    // Parser phase, one-hot.
    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_HEADER = 3'b010,
        PH_PDU    = 3'b100
    } phase_t;

    // One queued result item.
    typedef struct packed {
        logic                              is_status;
        logic [mtrc_pkg::WordWidth-1:0]    payload_value;
        logic [mtrc_pkg::StatusWidth-1:0]  status;
        logic [mtrc_pkg::ByteWidth-1:0]    exception_code;
    } res_t;

    localparam int QueueDepth = 3;

    // Parser state.
    phase_t                 phase_reg, phase_next;
    logic [15:0]            idx_reg, idx_next;
    logic [15:0]            tidw_reg, tidw_next;
    logic [7:0]             fcw_reg, fcw_next;
    logic [15:0]            tid_reg, tid_next;
    logic [15:0]            proto_reg, proto_next;
    logic [15:0]            len_reg, len_next;
    logic [7:0]             count_reg, count_next;
    logic [7:0]             hold_reg, hold_next;
    mtrc_pkg::verdict_t     verdict_reg, verdict_next;
    logic [7:0]             exc_reg, exc_next;

    // Result queue; the head always sits in entry 0.
    res_t                   q_reg [QueueDepth];
    res_t                   q_next [QueueDepth];
    logic [1:0]             fill_reg, fill_next;

    logic                   accept;
    logic                   pop;
    logic                   pay_push;
    logic                   st_push;
    logic [15:0]            pay_value;
    mtrc_pkg::verdict_t     st_value;
    logic [7:0]             st_exc;
    logic [7:0]             b;
    logic [15:0]            pdu_len;
    logic [15:0]            data_pos;
    logic                   reads;
    res_t                   pay_item;
    res_t                   st_item;
    logic [1:0]             slot;

    assign bytes.ready = (fill_reg <= 2'd1);
    assign accept      = bytes.valid && bytes.ready;
    assign pop         = results.valid && results.ready;
    assign b           = bytes.data_byte;
    assign pdu_len     = len_reg - 16'd1;
    assign data_pos    = idx_reg - 16'd2;
    assign reads       = (fcw_reg == mtrc_pkg::FcCoils) || (fcw_reg == mtrc_pkg::FcRegs);

    // Parser: all checks for one byte are short compares on held header fields.
    always_comb
    begin
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        tidw_next    = tidw_reg;
        fcw_next     = fcw_reg;
        tid_next     = tid_reg;
        proto_next   = proto_reg;
        len_next     = len_reg;
        count_next   = count_reg;
        hold_next    = hold_reg;
        verdict_next = verdict_reg;
        exc_next     = exc_reg;
        pay_push     = 1'b0;
        pay_value    = 16'd0;
        st_push      = 1'b0;
        st_value     = mtrc_pkg::VERDICT_OK;
        st_exc       = 8'd0;

        if (accept)
        begin
            if (!bytes.cmd)
            begin
                tidw_next    = bytes.expected_tid;
                fcw_next     = bytes.expected_fc;
                phase_next   = PH_HEADER;
                idx_next     = 16'd0;
                tid_next     = 16'd0;
                proto_next   = 16'd0;
                len_next     = 16'd0;
                count_next   = 8'd0;
                hold_next    = 8'd0;
                verdict_next = mtrc_pkg::VERDICT_OK;
                exc_next     = 8'd0;
            end
            else
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        case (idx_reg[2:0])
                            3'd0:    tid_next[15:8]   = b;
                            3'd1:    tid_next[7:0]    = b;
                            3'd2:    proto_next[15:8] = b;
                            3'd3:    proto_next[7:0]  = b;
                            3'd4:    len_next[15:8]   = b;
                            3'd5:    len_next[7:0]    = b;
                            default: ;
                        endcase
                        if (idx_reg < mtrc_pkg::HeaderLast)
                        begin
                            idx_next = idx_reg + 16'd1;
                        end
                        else if ((proto_reg != mtrc_pkg::ProtoZero) || (len_reg < 16'd2))
                        begin
                            // Bad header: the frame ends on its last header byte.
                            st_push    = 1'b1;
                            st_value   = mtrc_pkg::VERDICT_INVALID;
                            phase_next = PH_IDLE;
                            idx_next   = 16'd0;
                        end
                        else
                        begin
                            verdict_next = (tid_reg != tidw_reg) ? mtrc_pkg::VERDICT_INVALID
                                                                 : mtrc_pkg::VERDICT_OK;
                            phase_next   = PH_PDU;
                            idx_next     = 16'd0;
                        end
                    end
                    PH_PDU:
                    begin
                        if (idx_reg == 16'd0)
                        begin
                            if (verdict_reg == mtrc_pkg::VERDICT_OK)
                            begin
                                if (b == (fcw_reg | mtrc_pkg::ExcFlag))
                                begin
                                    verdict_next = mtrc_pkg::VERDICT_EXCEPTION;
                                    exc_next     = 8'd0;
                                end
                                else if (reads && (pdu_len < 16'd2))
                                begin
                                    verdict_next = mtrc_pkg::VERDICT_INVALID;
                                end
                            end
                        end
                        else if (idx_reg == 16'd1)
                        begin
                            count_next = b;
                            if (verdict_reg == mtrc_pkg::VERDICT_EXCEPTION)
                            begin
                                exc_next = b;
                                if (b == mtrc_pkg::BusyCode)
                                begin
                                    verdict_next = mtrc_pkg::VERDICT_BUSY;
                                end
                            end
                            else if ((verdict_reg == mtrc_pkg::VERDICT_OK) && reads &&
                                     ((pdu_len - 16'd2) < {8'd0, b}))
                            begin
                                verdict_next = mtrc_pkg::VERDICT_INVALID;
                            end
                        end
                        else if ((verdict_reg == mtrc_pkg::VERDICT_OK) && reads)
                        begin
                            if (data_pos < {8'd0, count_reg})
                            begin
                                if (fcw_reg == mtrc_pkg::FcCoils)
                                begin
                                    pay_push  = 1'b1;
                                    pay_value = {8'd0, b};
                                end
                                else if (!idx_reg[0])
                                begin
                                    hold_next = b;
                                end
                                else
                                begin
                                    pay_push  = 1'b1;
                                    pay_value = {hold_reg, b};
                                end
                            end
                        end

                        if (({1'b0, idx_reg} + 17'd1) >= {1'b0, pdu_len})
                        begin
                            st_push    = 1'b1;
                            st_value   = verdict_next;
                            st_exc     = ((verdict_next == mtrc_pkg::VERDICT_EXCEPTION) ||
                                          (verdict_next == mtrc_pkg::VERDICT_BUSY))
                                         ? exc_next : 8'd0;
                            phase_next = PH_IDLE;
                            idx_next   = 16'd0;
                        end
                        else
                        begin
                            idx_next = idx_reg + 16'd1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        pay_item                = '0;
        pay_item.payload_value  = pay_value;
        st_item                 = '0;
        st_item.is_status       = 1'b1;
        st_item.status          = st_value;
        st_item.exception_code  = st_exc;
    end

    // Result queue: shift out the head, then append payload before status.
    always_comb
    begin
        q_next    = q_reg;
        fill_next = fill_reg;
        slot      = fill_reg;
        if (pop)
        begin
            q_next[0] = q_reg[1];
            q_next[1] = q_reg[2];
            slot      = fill_reg - 2'd1;
        end
        if (pay_push)
        begin
            q_next[slot] = pay_item;
            slot         = slot + 2'd1;
        end
        if (st_push)
        begin
            q_next[slot] = st_item;
            slot         = slot + 2'd1;
        end
        fill_next = slot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            idx_reg     <= 16'd0;
            tidw_reg    <= 16'd0;
            fcw_reg     <= 8'd0;
            tid_reg     <= 16'd0;
            proto_reg   <= 16'd0;
            len_reg     <= 16'd0;
            count_reg   <= 8'd0;
            hold_reg    <= 8'd0;
            verdict_reg <= mtrc_pkg::VERDICT_OK;
            exc_reg     <= 8'd0;
            fill_reg    <= 2'd0;
        end
        else
        begin
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            tidw_reg    <= tidw_next;
            fcw_reg     <= fcw_next;
            tid_reg     <= tid_next;
            proto_reg   <= proto_next;
            len_reg     <= len_next;
            count_reg   <= count_next;
            hold_reg    <= hold_next;
            verdict_reg <= verdict_next;
            exc_reg     <= exc_next;
            fill_reg    <= fill_next;
        end
    end

    // Queue payload carries no reset; the fill count qualifies it.
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign results.valid          = (fill_reg != 2'd0);
    assign results.is_status      = q_reg[0].is_status;
    assign results.payload_value  = q_reg[0].payload_value;
    assign results.status         = q_reg[0].status;
    assign results.exception_code = q_reg[0].exception_code;
    assign results.last           = q_reg[0].is_status;

    // A status result always closes the frame.
    `MTRC_ASSERT_NEXT(a_status_closes_frame, st_push, phase_reg == PH_IDLE)
    // Payload only comes from the PDU of a frame whose checks all passed.
    `MTRC_ASSERT_IMPLY(a_payload_on_good_frame, pay_push, (phase_reg == PH_PDU) && (verdict_reg == mtrc_pkg::VERDICT_OK))
    // The header counter never runs past the unit id byte.
    `MTRC_ASSERT_IMPLY(a_header_index_range, phase_reg == PH_HEADER, idx_reg <= mtrc_pkg::HeaderLast)
    // The queue never overflows its three entries.
    `MTRC_ASSERT_IMPLY(a_queue_fill_range, 1'b1, fill_reg != 2'd3 || !accept)

endmodule

`default_nettype wire
